[rtl/idea_pkg.sv]
package idea_pkg;

  localparam int NSUB = 52;
  localparam int NRND = 8;
  localparam int NINV = 18;

  typedef logic [15:0] word_t;
  typedef logic [3:0][15:0] words_t;
  typedef logic [5:0][15:0] rkey_t;
  typedef logic [NSUB-1:0][15:0] skey_t;
  typedef logic [32:0] prod_t;

  typedef struct packed {
    logic   mode;
    words_t x;
  } blk_t;

  // zero operand stands for 65536
  function automatic prod_t mprod(word_t a, word_t b);
    logic [16:0] ea;
    logic [16:0] eb;
    logic [33:0] full;
    ea = (a == 16'd0) ? 17'h10000 : {1'b0, a};
    eb = (b == 16'd0) ? 17'h10000 : {1'b0, b};
    full = {17'd0, ea} * {17'd0, eb};
    return full[32:0];
  endfunction

  // reduce modulo 65537 as lo - hi with borrow fix
  function automatic word_t mred(prod_t p);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [16:0] d;
    lo = {1'b0, p[15:0]};
    hi = p[32:16];
    d = lo - hi + ((lo < hi) ? 17'd1 : 17'd0);
    return d[15:0];
  endfunction

  function automatic word_t mmul(word_t a, word_t b);
    return mred(mprod(a, b));
  endfunction

endpackage

[rtl/idea_keysched.sv]
module idea_keysched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output idea_pkg::skey_t     fwd_o,
  output idea_pkg::skey_t     inv_o,
  output logic                busy_o
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [4:0]             j_q;
  logic [3:0]             k_q;
  idea_pkg::word_t        acc_q;
  idea_pkg::word_t        sq_q;
  idea_pkg::word_t        key_q [8];
  idea_pkg::word_t        inv_q [idea_pkg::NINV];
  idea_pkg::skey_t        fk;
  idea_pkg::skey_t        ik;
  logic [5:0]             src;
  idea_pkg::word_t        acc_d;

  // rotation schedule is pure wiring
  always_comb begin
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    for (int i = 0; i < 8; i++) begin
      fk[i] = key_q[i];
    end
    for (int i = 8; i < idea_pkg::NSUB; i++) begin
      ia = (((i + 1) & 7) != 0) ? i - 7 : i - 15;
      ib = (((i + 2) & 7) < 2) ? i - 14 : i - 6;
      fk[i] = {fk[ia][6:0], fk[ib][15:7]};
    end
  end

  always_comb begin
    int b;
    b = 0;
    ik[0] = inv_q[0];
    ik[1] = 16'(16'd0 - fk[49]);
    ik[2] = 16'(16'd0 - fk[50]);
    ik[3] = inv_q[1];
    ik[4] = fk[46];
    ik[5] = fk[47];
    for (int r = 1; r < idea_pkg::NRND; r++) begin
      b = 48 - 6 * r;
      ik[6*r]     = inv_q[2*r];
      ik[6*r + 1] = 16'(16'd0 - fk[b + 2]);
      ik[6*r + 2] = 16'(16'd0 - fk[b + 1]);
      ik[6*r + 3] = inv_q[2*r + 1];
      ik[6*r + 4] = fk[b - 2];
      ik[6*r + 5] = fk[b - 1];
    end
    ik[48] = inv_q[16];
    ik[49] = 16'(16'd0 - fk[1]);
    ik[50] = 16'(16'd0 - fk[2]);
    ik[51] = inv_q[17];
  end

  // inverse j comes from subkey 48 - 6*(j/2), plus 3 for odd j
  assign src = 6'(6'd48 - 6'd6 * {2'd0, j_q[4:1]} + (j_q[0] ? 6'd3 : 6'd0));
  assign acc_d = idea_pkg::mmul(acc_q, sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // inverse by a^65535: square and multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      j_q     <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      sq_q    <= '0;
    end else if (cfg_we_i) begin
      state_q <= S_LOAD;
      j_q     <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          acc_q   <= 16'd1;
          sq_q    <= fk[src];
          k_q     <= '0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          acc_q <= acc_d;
          sq_q  <= idea_pkg::mmul(sq_q, sq_q);
          k_q   <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            if (j_q == 5'(idea_pkg::NINV - 1)) begin
              state_q <= S_DONE;
            end else begin
              j_q     <= j_q + 5'd1;
              state_q <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          state_q <= S_DONE;
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cfg_we_i && state_q == S_RUN && k_q == 4'd15) begin
      inv_q[j_q] <= acc_d;
    end
  end

  assign fwd_o  = fk;
  assign inv_o  = ik;
  assign busy_o = (state_q != S_DONE);

endmodule

[rtl/idea_round.sv]
module idea_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  idea_pkg::blk_t     in_blk_i,
  output logic               in_stall_o,
  input  idea_pkg::rkey_t    kf_i,
  input  idea_pkg::rkey_t    ki_i,
  output logic               out_valid_o,
  output idea_pkg::blk_t     out_blk_o,
  input  logic               out_stall_i
);

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                adv1, adv2, adv3, adv4;
  logic                m1_q, m2_q, m3_q;
  idea_pkg::prod_t     p1_q, p4_q, pp_q, qp_q;
  idea_pkg::word_t     a2_1_q, a3_1_q;
  idea_pkg::word_t     y1_2_q, y4_2_q, a2_2_q, a3_2_q;
  idea_pkg::word_t     y1_3_q, y4_3_q, a2_3_q, a3_3_q, p_3_q;
  idea_pkg::blk_t      blk4_q;
  idea_pkg::rkey_t     k1, k2, k3;
  idea_pkg::word_t     y1, y4, p, t, q, s;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  assign k1 = in_blk_i.mode ? ki_i : kf_i;
  assign k2 = m1_q ? ki_i : kf_i;
  assign k3 = m2_q ? ki_i : kf_i;

  assign y1 = idea_pkg::mred(p1_q);
  assign y4 = idea_pkg::mred(p4_q);
  assign p  = idea_pkg::mred(pp_q);
  assign t  = 16'(p + (a2_2_q ^ y4_2_q));
  assign q  = idea_pkg::mred(qp_q);
  assign s  = 16'(p_3_q + q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      m1_q   <= in_blk_i.mode;
      p1_q   <= idea_pkg::mprod(in_blk_i.x[0], k1[0]);
      p4_q   <= idea_pkg::mprod(in_blk_i.x[3], k1[3]);
      a2_1_q <= 16'(in_blk_i.x[1] + k1[1]);
      a3_1_q <= 16'(in_blk_i.x[2] + k1[2]);
    end
    if (adv2) begin
      m2_q   <= m1_q;
      y1_2_q <= y1;
      y4_2_q <= y4;
      a2_2_q <= a2_1_q;
      a3_2_q <= a3_1_q;
      pp_q   <= idea_pkg::mprod(k2[4], y1 ^ a3_1_q);
    end
    if (adv3) begin
      m3_q   <= m2_q;
      y1_3_q <= y1_2_q;
      y4_3_q <= y4_2_q;
      a2_3_q <= a2_2_q;
      a3_3_q <= a3_2_q;
      p_3_q  <= p;
      qp_q   <= idea_pkg::mprod(k3[5], t);
    end
    if (adv4) begin
      blk4_q.mode <= m3_q;
      blk4_q.x[0] <= y1_3_q ^ q;
      blk4_q.x[1] <= a3_3_q ^ q;
      blk4_q.x[2] <= a2_3_q ^ s;
      blk4_q.x[3] <= y4_3_q ^ s;
    end
  end

  assign out_valid_o = v4_q;
  assign out_blk_o   = blk4_q;

endmodule

[rtl/idea_out.sv]
module idea_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  idea_pkg::blk_t     in_blk_i,
  output logic               in_stall_o,
  input  idea_pkg::words_t   kf_i,
  input  idea_pkg::words_t   ki_i,
  output logic               out_valid_o,
  output idea_pkg::words_t   out_o,
  input  logic               out_stall_i
);

  logic                v1_q, v2_q;
  logic                adv1, adv2;
  idea_pkg::words_t    k;
  idea_pkg::prod_t     p0_q, p3_q;
  idea_pkg::word_t     o1_q, o2_q;
  idea_pkg::words_t    res_q;

  assign adv2 = !v2_q || !out_stall_i;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign k = in_blk_i.mode ? ki_i : kf_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  // middle words swap back on the way out
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      p0_q <= idea_pkg::mprod(in_blk_i.x[0], k[0]);
      p3_q <= idea_pkg::mprod(in_blk_i.x[3], k[3]);
      o1_q <= 16'(in_blk_i.x[2] + k[1]);
      o2_q <= 16'(in_blk_i.x[1] + k[2]);
    end
    if (adv2) begin
      res_q[0] <= idea_pkg::mred(p0_q);
      res_q[1] <= o1_q;
      res_q[2] <= o2_q;
      res_q[3] <= idea_pkg::mred(p3_q);
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = res_q;

endmodule

[rtl/idea_block_cipher_top.sv]
// IDEA block cipher, ECB, 128-bit key. One 64-bit block is accepted per cycle
// while in_stall_o is low and passes eight rounds of four register stages each
// (with 17x17 modular multiplies) plus two stages of output transform. Stalls
// ripple back stage by stage, so empty slots are filled even while the output
// is held. After reset and after every key word write the block refuses items
// while a single square-and-multiply unit computes the 18 multiplicative
// inverses for decryption; the encryption subkeys are wired straight from the
// key registers.
module idea_block_cipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] block_in_0_i,
  input  logic [15:0] block_in_1_i,
  input  logic [15:0] block_in_2_i,
  input  logic [15:0] block_in_3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] block_out_0_o,
  output logic [15:0] block_out_1_o,
  output logic [15:0] block_out_2_o,
  output logic [15:0] block_out_3_o
);

  idea_pkg::skey_t              fk;
  idea_pkg::skey_t              ik;
  logic                         ks_busy;
  logic [idea_pkg::NRND:0]      vld;
  logic [idea_pkg::NRND:0]      stl;
  idea_pkg::blk_t               blk [idea_pkg::NRND+1];
  idea_pkg::words_t             res;

  idea_keysched u_keysched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fwd_o      (fk),
    .inv_o      (ik),
    .busy_o     (ks_busy)
  );

  assign vld[0]         = in_valid_i && !ks_busy;
  assign blk[0].mode    = mode_i;
  assign blk[0].x[0]    = block_in_0_i;
  assign blk[0].x[1]    = block_in_1_i;
  assign blk[0].x[2]    = block_in_2_i;
  assign blk[0].x[3]    = block_in_3_i;
  assign in_stall_o     = stl[0] || ks_busy;

  for (genvar r = 0; r < idea_pkg::NRND; r++) begin : g_round
    idea_round u_round (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[r]),
      .in_blk_i    (blk[r]),
      .in_stall_o  (stl[r]),
      .kf_i        (fk[6*r +: 6]),
      .ki_i        (ik[6*r +: 6]),
      .out_valid_o (vld[r+1]),
      .out_blk_o   (blk[r+1]),
      .out_stall_i (stl[r+1])
    );
  end

  idea_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[idea_pkg::NRND]),
    .in_blk_i    (blk[idea_pkg::NRND]),
    .in_stall_o  (stl[idea_pkg::NRND]),
    .kf_i        (fk[48 +: 4]),
    .ki_i        (ik[48 +: 4]),
    .out_valid_o (out_valid_o),
    .out_o       (res),
    .out_stall_i (out_stall_i)
  );

  assign block_out_0_o = res[0];
  assign block_out_1_o = res[1];
  assign block_out_2_o = res[2];
  assign block_out_3_o = res[3];

  // no item enters while subkeys are being derived
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !ks_busy)
    else $error("item accepted during key expansion");

  // a key write always restarts the inverse computation
  a_write_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> ks_busy)
    else $error("key write did not restart expansion");

  // once done, expansion only resumes after a key write
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ks_busy && !cfg_we_i) |=> !ks_busy)
    else $error("key expansion restarted without a write");

endmodule
